[src/assert_macros.svh]
// Assertion macros used by mass_damper_integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

[src/mdi_pkg.sv]
// ----------------------------------------------------------------------------
// mdi_pkg
// Shared types and codes of the mass-damper integrator.
// ----------------------------------------------------------------------------
package mdi_pkg;
    localparam logic [1:0] METHOD_EULER = 2'd0;
    localparam logic [1:0] METHOD_RK4   = 2'd1;
    localparam logic [1:0] REG_MASS     = 2'd0;
    localparam logic [1:0] REG_DAMPING  = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;
    localparam logic [1:0] REG_METHOD   = 2'd3;

    // Request to the serial arithmetic unit.
    typedef struct packed {
        logic       start;
        logic       is_div;   // 1: round(a*2^F/b), 0: round(a*b/(k*2^F))
        logic       flip;     // 1: the result takes the opposite sign
        logic [2:0] den_k;    // 1, 2 or 6 for multiply
    } mdi_op_t;
endpackage

[src/mdi_arith.sv]
// ----------------------------------------------------------------------------
// mdi_arith
// Bit-serial multiply-then-divide unit with round to nearest and saturation.
// ----------------------------------------------------------------------------
module mdi_arith #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mdi_pkg::mdi_op_t            op,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] y
);
    import mdi_pkg::*;

    // product / numerator width: the larger of a full product and a scaled dividend
    localparam int PW = ((WORD_BITS >= FRAC_BITS) ? 2 * WORD_BITS
                                                  : WORD_BITS + FRAC_BITS) + 4;
    localparam int CW = $clog2(PW + 1);
    localparam int KW = WORD_BITS + FRAC_BITS + 3;  // divisor width

    typedef enum logic [1:0] { S_IDLE, S_MUL, S_DIV, S_FIN } st_t;

    st_t               st_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     num_reg;   // product, then quotient
    logic [KW:0]       rem_reg;
    logic [KW-1:0]     den_reg;
    logic [WORD_BITS-1:0] mb_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic signed [WORD_BITS-1:0] y_reg;
    logic              done_reg;

    logic [WORD_BITS-1:0] ma, mbv;
    logic [KW:0]          rsh;
    logic [PW-1:0]        half_w;
    logic [PW-1:0]        lim;

    assign ma  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    assign mbv = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
    assign rsh = {rem_reg[KW-1:0], num_reg[PW-1]};
    assign lim = neg_reg ? (PW'(1) << (WORD_BITS - 1))
                         : ((PW'(1) << (WORD_BITS - 1)) - PW'(1));

    always_comb
    begin
        half_w = PW'(den_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (op.start)
                    begin
                        neg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1] ^ op.flip;
                        if (op.is_div)
                        begin
                            num_reg  <= PW'(ma) << FRAC_BITS;
                            den_reg  <= KW'(mbv);
                            zero_reg <= (mbv == '0);
                            rem_reg  <= '0;
                            cnt_reg  <= '0;
                            st_reg   <= S_FIN;  // numerator ready; round then divide
                            mb_reg   <= '0;
                        end
                        else
                        begin
                            num_reg  <= '0;
                            mb_reg   <= mbv;
                            den_reg  <= KW'(op.den_k) << FRAC_BITS;
                            zero_reg <= 1'b0;
                            cnt_reg  <= CW'(WORD_BITS);
                            rem_reg  <= (KW+1)'(ma);
                            st_reg   <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    // shift-add, one multiplier bit a cycle (msb first)
                    num_reg <= (num_reg << 1)
                             + (mb_reg[WORD_BITS-1] ? PW'(rem_reg) : PW'(0));
                    mb_reg  <= mb_reg << 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        st_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (zero_reg)
                    begin
                        if (num_reg == '0)
                            y_reg <= '0;
                        else
                            y_reg <= neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                             : {1'b0, {(WORD_BITS-1){1'b1}}};
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                    else
                    begin
                        num_reg <= num_reg + half_w;
                        rem_reg <= '0;
                        cnt_reg <= CW'(PW);
                        st_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (cnt_reg == '0)
                    begin
                        y_reg <= (num_reg > lim)
                            ? (neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                       : {1'b0, {(WORD_BITS-1){1'b1}}})
                            : (neg_reg ? WORD_BITS'(-num_reg) : WORD_BITS'(num_reg));
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        if (rsh >= (KW+1)'(den_reg))
                        begin
                            rem_reg <= rsh - (KW+1)'(den_reg);
                            num_reg <= {num_reg[PW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            num_reg <= {num_reg[PW-2:0], 1'b0};
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
endmodule

[src/mass_damper_integrator.sv]
// One step at a time: the next input transfer can come in the cycle after the
// result enters the output register.
// Reset (rst_n, asynchronous) clears position, velocity and the output stage,
// and loads the default mass, damping, step and method registers.
// ----------------------------------------------------------------------------
// mass_damper_integrator
// Steps a mass-damper system by Euler or RK4 using a serial arithmetic unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mass_damper_integrator #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // applied_force[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // position[31:0], velocity[63:32], prior_position[95:64],
    // prior_velocity[127:96], status[128], zero fill
    output logic [135:0] m_tdata
);
    import mdi_pkg::*;

    localparam int W = WORD_BITS;
    typedef logic signed [W-1:0] w_t;

    // Runge-Kutta and Euler share one sequence of slots. Each arithmetic slot
    // issues a request for one cycle and then waits in its W phase for done.
    typedef enum logic [4:0] {
        P_IDLE, P_FM, P_FMW, P_DM, P_DMW, P_ACC, P_ACCW, P_UPD, P_UPDW,
        P_FINP, P_FINPW, P_FINV, P_FINVW, P_OUT
    } ph_t;

    logic [30:0] mass_reg, step_reg;
    logic [31:0] damp_reg;
    logic [1:0]  meth_reg;

    ph_t  ph_reg;
    logic [1:0] stage_reg;   // RK stage 0..3
    w_t   f_reg, fm_reg, dm_reg, p_reg, v_reg, u_reg, k_reg, sp_reg, sv_reg;
    w_t   np_reg, nv_reg;
    logic busy_reg, stat_reg, ovalid_reg;
    logic [135:0] odata_reg;

    mdi_op_t op;
    w_t      op_a, op_b, ar_y;
    logic    ar_done;

    function automatic w_t sat_ext(input logic signed [63:0] x);
        logic signed [63:0] hi, lo;
        hi = 64'sd1 <<< (W - 1);
        lo = -hi;
        hi = hi - 64'sd1;
        if (x > hi) return W'(hi);
        if (x < lo) return W'(lo);
        return W'(x);
    endfunction

    function automatic w_t sadd(input w_t x, input w_t y);
        logic signed [W:0] s;
        s = (W+1)'(x) + (W+1)'(y);
        if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return W'(s);
    endfunction

    // Output fields are 32 bits; wider words saturate into them.
    function automatic logic [31:0] out32(input w_t x);
        logic signed [63:0] t;
        t = 64'(x);
        if (t > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (t < -64'sd2147483648) return 32'h8000_0000;
        return t[31:0];
    endfunction

    mdi_arith #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_arith (
        .clk(clk), .rst_n(rst_n), .op(op), .a(op_a), .b(op_b),
        .done(ar_done), .y(ar_y)
    );

    assign pready   = 1'b1;
    assign s_tready = !busy_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MASS:    prdata = {1'b0, mass_reg};
            REG_DAMPING: prdata = damp_reg;
            REG_STEP:    prdata = {1'b0, step_reg};
            default:     prdata = {30'd0, meth_reg};
        endcase
    end

    // Operand selection for the arithmetic unit per phase.
    always_comb
    begin
        op = '0;
        op_a = '0;
        op_b = '0;
        op.den_k = 3'd1;
        unique case (ph_reg)
            P_FM:
            begin
                op.start = 1'b1; op.is_div = 1'b1;
                op_a = f_reg; op_b = sat_ext(64'($unsigned(mass_reg)));
            end
            P_DM:
            begin
                op.start = 1'b1; op.is_div = 1'b1;
                op_a = sat_ext(64'($signed(damp_reg)));
                op_b = sat_ext(64'($unsigned(mass_reg)));
            end
            P_ACC:
            begin
                // The damping term is subtracted, so its sign is flipped here.
                op.start = 1'b1; op.flip = 1'b1; op_a = dm_reg; op_b = u_reg;
            end
            P_UPD:
            begin
                // The last stage only accumulates and needs no product.
                op.start = (stage_reg != 2'd3); op_a = k_reg;
                op_b = sat_ext(64'($unsigned(step_reg)));
                op.den_k = (stage_reg == 2'd2 || meth_reg == METHOD_EULER) ? 3'd1 : 3'd2;
            end
            P_FINP:
            begin
                op.start = 1'b1; op_a = sat_ext(64'($unsigned(step_reg)));
                op_b = (meth_reg == METHOD_EULER) ? v_reg : sp_reg;
                op.den_k = (meth_reg == METHOD_EULER) ? 3'd1 : 3'd6;
            end
            P_FINV:
            begin
                op.start = 1'b1; op_a = sat_ext(64'($unsigned(step_reg)));
                op_b = (meth_reg == METHOD_EULER) ? k_reg : sv_reg;
                op.den_k = (meth_reg == METHOD_EULER) ? 3'd1 : 3'd6;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= 31'd65536;
            damp_reg   <= '0;
            step_reg   <= 31'd66;
            meth_reg   <= METHOD_EULER;
            ph_reg     <= P_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            p_reg      <= '0;
            v_reg      <= '0;
            stage_reg  <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_MASS:    mass_reg <= pwdata[30:0];
                    REG_DAMPING: damp_reg <= pwdata;
                    REG_STEP:    step_reg <= pwdata[30:0];
                    default:     meth_reg <= pwdata[1:0];
                endcase
            end

            // The output register loads in P_OUT once it is empty or draining.
            if (ph_reg == P_OUT && (!ovalid_reg || m_tready))
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;

            unique case (ph_reg)
                P_IDLE:
                begin
                    if (s_tvalid && !busy_reg)
                    begin
                        busy_reg <= 1'b1;
                        f_reg    <= sat_ext(64'($signed(s_tdata)));
                        np_reg   <= p_reg;
                        nv_reg   <= v_reg;
                        stat_reg <= (meth_reg != METHOD_EULER) && (meth_reg != METHOD_RK4);
                        ph_reg   <= ((meth_reg == METHOD_EULER) || (meth_reg == METHOD_RK4))
                                    ? P_FM : P_OUT;
                    end
                end
                P_FM:  ph_reg <= P_FMW;
                P_FMW:
                begin
                    if (ar_done)
                    begin
                        fm_reg <= ar_y;
                        ph_reg <= P_DM;
                    end
                end
                P_DM:  ph_reg <= P_DMW;
                P_DMW:
                begin
                    if (ar_done)
                    begin
                        dm_reg    <= ar_y;
                        u_reg     <= v_reg;
                        sp_reg    <= v_reg;
                        stage_reg <= '0;
                        ph_reg    <= P_ACC;
                    end
                end
                P_ACC: ph_reg <= P_ACCW;
                P_ACCW:
                begin
                    // acceleration: F/m plus the sign-flipped damping product
                    if (ar_done)
                    begin
                        k_reg  <= sadd(fm_reg, ar_y);
                        ph_reg <= (meth_reg == METHOD_EULER) ? P_FINP : P_UPD;
                    end
                end
                P_UPD:
                begin
                    // Weighted sums: stages one and two count twice.
                    if (stage_reg == 2'd0)
                    begin
                        sv_reg <= k_reg;
                    end
                    else if (stage_reg == 2'd3)
                    begin
                        sv_reg <= sadd(sv_reg, k_reg);
                        sp_reg <= sadd(sp_reg, u_reg);
                    end
                    else
                    begin
                        sv_reg <= sadd(sadd(sv_reg, k_reg), k_reg);
                        sp_reg <= sadd(sadd(sp_reg, u_reg), u_reg);
                    end
                    if (stage_reg == 2'd3)
                        ph_reg <= P_FINP;
                    else
                    begin
                        stage_reg <= stage_reg + 2'd1;
                        ph_reg    <= P_UPDW;
                    end
                end
                P_UPDW:
                begin
                    if (ar_done)
                    begin
                        u_reg  <= sadd(v_reg, ar_y);
                        ph_reg <= P_ACC;
                    end
                end
                P_FINP: ph_reg <= P_FINPW;
                P_FINPW:
                begin
                    if (ar_done)
                    begin
                        np_reg <= sadd(p_reg, ar_y);
                        ph_reg <= P_FINV;
                    end
                end
                P_FINV: ph_reg <= P_FINVW;
                P_FINVW:
                begin
                    if (ar_done)
                    begin
                        nv_reg <= sadd(v_reg, ar_y);
                        ph_reg <= P_OUT;
                    end
                end
                P_OUT:
                begin
                    if (!ovalid_reg || m_tready)
                    begin
                        odata_reg  <= {7'd0, stat_reg, out32(v_reg), out32(p_reg),
                                       out32(nv_reg), out32(np_reg)};
                        p_reg      <= np_reg;
                        v_reg      <= nv_reg;
                        busy_reg   <= 1'b0;
                        ph_reg     <= P_IDLE;
                    end
                end
                default: ph_reg <= P_IDLE;
            endcase
        end
    end

    `CHK_IMPLY(a_no_accept_busy, clk, rst_n, busy_reg, !s_tready)
    `CHK_NEXT(a_out_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `CHK_IMPLY(a_idle_free, clk, rst_n, ph_reg == P_IDLE && !busy_reg, s_tready)
endmodule
